// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the circuit breaker RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define CBF_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("cbf: assertion failed");

// Condition in this cycle implies a consequence in the same cycle.
`define CBF_ASSERT_NOW(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("cbf: assertion failed");

// Condition in this cycle implies a consequence in the next cycle.
`define CBF_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("cbf: assertion failed");

`endif

// ----- hw/rtl/cbf_pkg.sv -----
// Types and constants of the circuit breaker block.
// No dependencies; imported by every cbf module.
package cbf_pkg;

  // Operation codes on the input tuser
  localparam logic [1:0] OP_REQUEST = 2'd0;
  localparam logic [1:0] OP_RESPONSE = 2'd1;
  localparam logic [1:0] OP_NET_ERROR = 2'd2;

  // Status code ranges
  localparam logic [9:0] CODE_OK_LO = 10'd200;
  localparam logic [9:0] CODE_OK_HI = 10'd300;
  localparam logic [9:0] CODE_CLIENT_LO = 10'd400;
  localparam logic [9:0] CODE_CLIENT_HI = 10'd500;

  // Breaker state codes
  localparam logic [1:0] MODE_CLOSED = 2'd0;
  localparam logic [1:0] MODE_OPEN = 2'd1;
  localparam logic [1:0] MODE_HALF = 2'd2;

  localparam logic [7:0] COUNT_MAX = 8'hFF;

  localparam logic [7:0] THRESHOLD_RST = 8'd5;
  localparam logic [31:0] DURATION_RST = 32'd30000;

  // Configuration register indexes
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_DURATION = 1'b1;

  typedef enum logic [1:0] {
    EV_NONE,
    EV_REQUEST,
    EV_SUCCESS,
    EV_FAILURE
  } ev_kind_e;

  typedef struct packed {
    ev_kind_e kind;
    logic [47:0] now_time;
  } ev_t;

  typedef struct packed {
    logic [7:0] failure_threshold;
    logic [31:0] open_duration;
  } cfg_t;

  typedef struct packed {
    logic [7:0] failure_count;
    logic [1:0] breaker_state;
    logic allowed;
  } res_t;

endpackage

// ----- hw/rtl/cbf_front.sv -----
// Front end of the circuit breaker: accepts input words and classifies them.
// Depends on cbf_pkg; feeds cbf_queue.
module cbf_front
  import cbf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [9:0]  resp_code_i,
  input  logic [47:0] now_time_i,
  output logic        ev_valid_o,
  input  logic        ev_ready_i,
  output ev_t         ev_o
);

  logic     vld_q, vld_d;
  ev_t      ev_q;
  ev_kind_e kind;
  logic     is_ok, is_client;
  logic     accept;

  assign is_ok = (resp_code_i >= CODE_OK_LO) && (resp_code_i < CODE_OK_HI);
  assign is_client = (resp_code_i >= CODE_CLIENT_LO) && (resp_code_i < CODE_CLIENT_HI);

  always_comb begin
    unique case (operation_i)
      OP_REQUEST:   kind = EV_REQUEST;
      OP_RESPONSE: begin
        if (is_ok) begin
          kind = EV_SUCCESS;
        end else if (is_client) begin
          kind = EV_NONE;
        end else begin
          kind = EV_FAILURE;
        end
      end
      OP_NET_ERROR: kind = EV_FAILURE;
      default:      kind = EV_NONE;
    endcase
  end

  assign in_ready_o = !vld_q || ev_ready_i;
  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (ev_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ev_q.kind <= kind;
      ev_q.now_time <= now_time_i;
    end
  end

  assign ev_valid_o = vld_q;
  assign ev_o = ev_q;

endmodule

// ----- hw/rtl/cbf_queue.sv -----
// Short event queue between the front and back ends of the circuit breaker.
// Depends on cbf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cbf_queue
  import cbf_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  ev_t  push_data_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output ev_t  pop_data_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  ev_t           mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          push, pop;

  assign push_ready_o = (count_q != CW'(DEPTH));
  assign pop_valid_o = (count_q != '0);
  assign push = push_valid_i && push_ready_o;
  assign pop = pop_valid_o && pop_ready_i;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `CBF_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CW'(DEPTH))
  `CBF_ASSERT_NEXT(a_both_hold, clk_i, rst_ni, push && pop, $stable(count_q))
  `CBF_ASSERT_NEXT(a_pop_drain, clk_i, rst_ni, pop && !push, count_q == $past(count_q) - 1'b1)

endmodule

// ----- hw/rtl/cbf_back.sv -----
// Back end of the circuit breaker: breaker state, failure count, result register.
// Depends on cbf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cbf_back
  import cbf_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic ev_valid_i,
  output logic ev_ready_o,
  input  ev_t  ev_i,
  output logic res_valid_o,
  input  logic res_ready_i,
  output res_t res_o
);

  logic [1:0]  mode_q, mode_d;
  logic [7:0]  fail_q, fail_d;
  logic [47:0] trip_q, trip_d;
  logic        out_vld_q, out_vld_d;
  res_t        res_q, res_d;
  logic [47:0] elapsed;
  logic        expired;
  logic [7:0]  fail_inc;
  logic        pop;

  assign ev_ready_o = !out_vld_q || res_ready_i;
  assign pop = ev_valid_i && ev_ready_o;

  // Modular 48-bit time since the trip
  assign elapsed = ev_i.now_time - trip_q;
  assign expired = elapsed >= {16'd0, cfg_i.open_duration};
  assign fail_inc = (fail_q != COUNT_MAX) ? fail_q + 1'b1 : fail_q;

  always_comb begin
    mode_d = mode_q;
    fail_d = fail_q;
    trip_d = trip_q;
    res_d.allowed = 1'b0;
    unique case (ev_i.kind)
      EV_REQUEST: begin
        if (mode_q != MODE_OPEN) begin
          res_d.allowed = 1'b1;
        end else if (expired) begin
          res_d.allowed = 1'b1;
          mode_d = MODE_HALF;
        end
      end
      EV_SUCCESS: begin
        if (mode_q == MODE_CLOSED) begin
          fail_d = '0;
        end else if (mode_q == MODE_HALF) begin
          fail_d = '0;
          mode_d = MODE_CLOSED;
        end
      end
      EV_FAILURE: begin
        fail_d = fail_inc;
        if ((mode_q == MODE_HALF) ||
            ((mode_q == MODE_CLOSED) && (fail_inc >= cfg_i.failure_threshold))) begin
          mode_d = MODE_OPEN;
          trip_d = ev_i.now_time;
        end
      end
      default: ;
    endcase
    res_d.breaker_state = mode_d;
    res_d.failure_count = fail_d;
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (pop) begin
      out_vld_d = 1'b1;
    end else if (res_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_CLOSED;
      fail_q <= '0;
      trip_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      if (pop) begin
        mode_q <= mode_d;
        fail_q <= fail_d;
        trip_q <= trip_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = out_vld_q;
  assign res_o = res_q;

  `CBF_ASSERT_NEXT(a_half_fail_trips, clk_i, rst_ni,
                   pop && (ev_i.kind == EV_FAILURE) && (mode_q == MODE_HALF),
                   (mode_q == MODE_OPEN) && (trip_q == $past(ev_i.now_time)))
  `CBF_ASSERT_NEXT(a_success_clears, clk_i, rst_ni,
                   pop && (ev_i.kind == EV_SUCCESS) && (mode_q != MODE_OPEN),
                   (fail_q == '0) && (mode_q == MODE_CLOSED))
  `CBF_ASSERT_NEXT(a_probe_grant, clk_i, rst_ni,
                   pop && (ev_i.kind == EV_REQUEST) && (mode_q == MODE_OPEN),
                   res_q.allowed == (mode_q == MODE_HALF))

endmodule

// ----- hw/rtl/circuit_breaker_fsm_top.sv -----
// A word passes the front register, the queue and the result register, in that order, before its result is valid.
// One word per cycle while no side stalls; the front register, a DEPTH-entry queue and the
// result register let each side stall without stopping the other.
// The back end settles each event with one 48-bit subtract and compare.
// Reset (rst_ni low, asynchronous): breaker closed, count and trip time zero,
// queue empty, threshold 5, open duration 30000 ticks.
module circuit_breaker_fsm_top
  import cbf_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // [9:0] resp_code, [57:10] now_time, rest zero
  input  logic [1:0]  s_axis_tuser,  // [1:0] operation
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [0] allowed, [2:1] breaker_state, [10:3] failure_count
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic        ev_valid, ev_ready;
  ev_t         ev_front;
  logic        q_valid, q_ready;
  ev_t         ev_queue;
  res_t        res;
  cfg_t        cfg_q;
  logic        cfg_wr;

  // Configuration registers: one word per register, index from address bit 2
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.failure_threshold <= THRESHOLD_RST;
      cfg_q.open_duration <= DURATION_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_THRESHOLD: cfg_q.failure_threshold <= pwdata[7:0];
        REG_DURATION:  cfg_q.open_duration <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_THRESHOLD: prdata = {24'd0, cfg_q.failure_threshold};
      REG_DURATION:  prdata = cfg_q.open_duration;
      default:       prdata = '0;
    endcase
  end

  // Front: take the word, classify the event, hold it for the queue
  cbf_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .operation_i   (s_axis_tuser),
    .resp_code_i   (s_axis_tdata[9:0]),
    .now_time_i    (s_axis_tdata[57:10]),
    .ev_valid_o    (ev_valid),
    .ev_ready_i    (ev_ready),
    .ev_o          (ev_front)
  );

  // Queue: decouple classification from the state update
  cbf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (ev_valid),
    .push_ready_o (ev_ready),
    .push_data_i  (ev_front),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (ev_queue)
  );

  // Back: advance the breaker state and register the result
  cbf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .ev_valid_i  (q_valid),
    .ev_ready_o  (q_ready),
    .ev_i        (ev_queue),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {5'd0, res};

endmodule
